>>> sv/hrd_pkg.sv
`timescale 1ns / 1ps
// Package for the HTTP response dechunker: phase codes, byte classes,
// error codes, header scan state and pattern/character helpers. No dependencies.
package hrd_pkg;

  typedef enum logic [3:0] {
    PH_HEADER   = 4'd0,
    PH_BODY_LEN = 4'd1,
    PH_BODY_RAW = 4'd2,
    PH_CH_LEAD  = 4'd3,
    PH_CH_DIGIT = 4'd4,
    PH_CH_EXT   = 4'd5,
    PH_CH_LF    = 4'd6,
    PH_CH_DATA  = 4'd7,
    PH_CH_TCR   = 4'd8,
    PH_CH_TLF   = 4'd9,
    PH_DONE     = 4'd10
  } phase_t;

  localparam logic [1:0] CLS_FRAMING = 2'd0;
  localparam logic [1:0] CLS_HEADER  = 2'd1;
  localparam logic [1:0] CLS_CONTENT = 2'd2;

  localparam logic [2:0] ERR_OK         = 3'd0;
  localparam logic [2:0] ERR_NO_STATUS  = 3'd1;
  localparam logic [2:0] ERR_NO_HDR_END = 3'd2;
  localparam logic [2:0] ERR_CHUNK      = 3'd3;
  localparam logic [2:0] ERR_LENGTH     = 3'd4;

  localparam logic [15:0] STATUS_NO_CONTENT = 16'd204;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam int STATUS_LEN  = 9;
  localparam int LENGTH_LEN  = 17;
  localparam int CHUNKED_LEN = 28;

  localparam logic [8*STATUS_LEN-1:0]  STATUS_PAT  = "HTTP/1.1 ";
  localparam logic [8*LENGTH_LEN-1:0]  LENGTH_PAT  = "\r\nContent-Length:";
  localparam logic [8*CHUNKED_LEN-1:0] CHUNKED_PAT = "\r\nTransfer-Encoding: chunked";

  // match positions: status 0..8 pattern, 9 spaces, 10 digits, 11 finished
  localparam logic [3:0] ST_SPACE  = 4'd9;
  localparam logic [3:0] ST_DIGITS = 4'd10;
  localparam logic [3:0] ST_FIN    = 4'd11;
  localparam logic [4:0] LN_SPACE  = 5'd17;
  localparam logic [4:0] LN_DIGITS = 5'd18;
  localparam logic [4:0] LN_FIN    = 5'd19;
  localparam logic [4:0] CK_FOUND  = 5'd28;

  typedef struct packed {
    logic [3:0]  status_pos;
    logic [4:0]  length_pos;
    logic [4:0]  chunked_pos;
    logic [1:0]  end_pos;
    logic [15:0] status_value;
    logic        status_seen;
    logic        length_seen;
    logic        chunked;
  } hdr_state_t;

  function automatic logic [7:0] status_char(input logic [3:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (pos < 4'(STATUS_LEN)) c = STATUS_PAT[8*(STATUS_LEN-1-int'(pos)) +: 8];
    return c;
  endfunction

  function automatic logic [7:0] length_char(input logic [4:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (pos < 5'(LENGTH_LEN)) c = LENGTH_PAT[8*(LENGTH_LEN-1-int'(pos)) +: 8];
    return c;
  endfunction

  function automatic logic [7:0] chunked_char(input logic [4:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (pos < 5'(CHUNKED_LEN)) c = CHUNKED_PAT[8*(CHUNKED_LEN-1-int'(pos)) +: 8];
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h57);
    else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h37);
    return v;
  endfunction

endpackage

>>> sv/hrd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the dechunker: received bytes in,
// tagged result items out. Depends on nothing.
interface hrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_data;
  modport source (output valid, rx_byte, end_of_data, input ready);
  modport sink (input valid, rx_byte, end_of_data, output ready);
endinterface

interface hrd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [1:0]  byte_class;
  logic        done_res;
  logic [15:0] status_code;
  logic [2:0]  error_code;
  logic [31:0] body_count;
  modport source (output valid, data_byte, byte_class, done_res, status_code,
                  error_code, body_count, input ready);
  modport sink (input valid, data_byte, byte_class, done_res, status_code,
                error_code, body_count, output ready);
endinterface

>>> sv/hrd_hdr_scan.sv
`timescale 1ns / 1ps
// Header scanner: next matcher state for one header byte (status line,
// Content-Length, chunked encoding, blank line). Uses hrd_pkg.
module hrd_hdr_scan import hrd_pkg::*; #(
  parameter int LENGTH_WIDTH = 32
) (
  input  hdr_state_t              cur,
  input  logic [LENGTH_WIDTH-1:0] length_value,
  input  logic [7:0]              b,
  output hdr_state_t              nxt,
  output logic [LENGTH_WIDTH-1:0] length_next,
  output logic                    hdr_end
);

  logic                    dig;
  logic [3:0]              dval;
  logic [19:0]             st_acc;
  logic [LENGTH_WIDTH+3:0] ln_acc;

  assign dig    = is_digit(b);
  assign dval   = 4'(b - CH_ZERO);
  assign st_acc = {4'd0, cur.status_value} * 20'd10 + 20'(dval);
  assign ln_acc = {length_value, 3'd0} + {3'd0, length_value, 1'b0}
                  + (LENGTH_WIDTH+4)'(dval);

  always_comb begin
    nxt         = cur;
    length_next = length_value;
    hdr_end     = 1'b0;

    if (cur.status_pos < ST_SPACE) begin
      if (cur.status_pos == 4'd7 && b == CH_ZERO) nxt.status_pos = 4'd8;
      else if (b == status_char(cur.status_pos)) nxt.status_pos = cur.status_pos + 4'd1;
      else nxt.status_pos = (b == status_char(4'd0)) ? 4'd1 : 4'd0;
    end else if (cur.status_pos == ST_SPACE) begin
      if (dig) begin
        nxt.status_value = 16'(dval);
        nxt.status_seen  = 1'b1;
        nxt.status_pos   = ST_DIGITS;
      end else if (b != CH_SPACE) begin
        nxt.status_pos = ST_FIN;
      end
    end else if (cur.status_pos == ST_DIGITS) begin
      if (dig) nxt.status_value = (st_acc > 20'hffff) ? 16'hffff : st_acc[15:0];
      else nxt.status_pos = ST_FIN;
    end

    if (cur.length_pos < LN_SPACE) begin
      if (b == length_char(cur.length_pos)) nxt.length_pos = cur.length_pos + 5'd1;
      else nxt.length_pos = (b == length_char(5'd0)) ? 5'd1 : 5'd0;
    end else if (cur.length_pos == LN_SPACE) begin
      if (dig) begin
        length_next     = LENGTH_WIDTH'(dval);
        nxt.length_seen = 1'b1;
        nxt.length_pos  = LN_DIGITS;
      end else if (b != CH_SPACE) begin
        nxt.length_pos = LN_FIN;
      end
    end else if (cur.length_pos == LN_DIGITS) begin
      if (dig) begin
        if (ln_acc[LENGTH_WIDTH+3:LENGTH_WIDTH] != 4'd0) length_next = '1;
        else length_next = ln_acc[LENGTH_WIDTH-1:0];
      end else begin
        nxt.length_pos = LN_FIN;
      end
    end

    if (cur.chunked_pos < CK_FOUND) begin
      if (b == chunked_char(cur.chunked_pos)) nxt.chunked_pos = cur.chunked_pos + 5'd1;
      else nxt.chunked_pos = (b == chunked_char(5'd0)) ? 5'd1 : 5'd0;
      if (nxt.chunked_pos == CK_FOUND) nxt.chunked = 1'b1;
    end

    case (cur.end_pos)
      2'd0: nxt.end_pos = (b == CH_CR) ? 2'd1 : 2'd0;
      2'd1: nxt.end_pos = (b == CH_LF) ? 2'd2 : ((b == CH_CR) ? 2'd1 : 2'd0);
      2'd2: nxt.end_pos = (b == CH_CR) ? 2'd3 : 2'd0;
      default: begin
        if (b == CH_LF) begin
          nxt.end_pos = 2'd0;
          hdr_end     = 1'b1;
        end else begin
          nxt.end_pos = (b == CH_CR) ? 2'd1 : 2'd0;
        end
      end
    endcase
  end

endmodule

>>> sv/http_response_dechunker_top.sv
`timescale 1ns / 1ps
// HTTP/1.x response dechunker, top level. Uses hrd_pkg, hrd_if and
// hrd_hdr_scan.
//
// Usage: received response bytes enter on "bytes" (rx_byte, end_of_data),
// one item per byte. Each byte yields exactly one item on "result": the byte
// tagged as header, content or framing, the running content count, and on
// completion (or on an end_of_data byte if not yet done) done_res with the status
// code and an error code. The byte flagged end_of_data rearms the parser.
// Latency: the result for a byte is valid the cycle after it is accepted.
// Throughput: one byte per clock while result is ready; the parse state and the result register
// update together, so back-to-back bytes flow with no bubbles.
// Stalls: while the result register holds an item that is not taken, bytes
// is not ready; nothing is dropped or repeated.
// Reset (rst, synchronous): parser returns to the header phase with all
// counters and match positions cleared; no result is valid.
module http_response_dechunker_top import hrd_pkg::*; #(
  parameter int LENGTH_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  hrd_in_if.sink    bytes,
  hrd_out_if.source result
);

  phase_t                  phase;
  phase_t                  phase_step;
  hdr_state_t              hdr;
  hdr_state_t              hdr_next;
  hdr_state_t              hdr_scan;
  logic [LENGTH_WIDTH-1:0] length_value;
  logic [LENGTH_WIDTH-1:0] length_next;
  logic [LENGTH_WIDTH-1:0] len_scan;
  logic [LENGTH_WIDTH-1:0] chunk_remaining;
  logic [LENGTH_WIDTH-1:0] chunk_next;
  logic [LENGTH_WIDTH-1:0] len_dec;
  logic [LENGTH_WIDTH-1:0] chunk_dec;
  logic [LENGTH_WIDTH-1:0] chunk_acc;
  logic [31:0]             content_counter;
  logic [31:0]             count_next;
  logic                    hdr_end;
  logic                    accept;
  logic                    hit_done;
  logic [2:0]              hit_err;
  logic                    is_content;
  logic                    is_hdr;
  logic                    fin_done;
  logic [2:0]              fin_err;
  logic [1:0]              cls;
  logic [4:0]              hx;
  logic [7:0]              b;
  logic                    out_valid;

  assign b            = bytes.rx_byte;
  assign accept       = bytes.valid && bytes.ready;
  assign bytes.ready  = !out_valid || result.ready;
  assign result.valid = out_valid;

  assign hx        = hex_val(b);
  assign len_dec   = length_value - LENGTH_WIDTH'(length_value != '0);
  assign chunk_dec = chunk_remaining - LENGTH_WIDTH'(chunk_remaining != '0);
  assign chunk_acc = (chunk_remaining[LENGTH_WIDTH-1 -: 4] != 4'd0) ? '1 :
                     {chunk_remaining[LENGTH_WIDTH-5:0], hx[3:0]};

  hrd_hdr_scan #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_scan (
    .cur          (hdr),
    .length_value (length_value),
    .b            (b),
    .nxt          (hdr_scan),
    .length_next  (len_scan),
    .hdr_end      (hdr_end)
  );

  // next phase and datapath
  always_comb begin
    phase_step  = phase;
    hdr_next    = hdr;
    length_next = length_value;
    chunk_next  = chunk_remaining;
    is_content  = 1'b0;
    is_hdr      = 1'b0;
    hit_done    = 1'b0;
    hit_err     = ERR_OK;
    unique case (phase)
      PH_HEADER: begin
        is_hdr      = 1'b1;
        hdr_next    = hdr_scan;
        length_next = len_scan;
        if (hdr_end) begin
          if (!hdr_scan.status_seen) begin
            hit_done = 1'b1;
            hit_err  = ERR_NO_STATUS;
          end else if (hdr_scan.chunked) begin
            phase_step = PH_CH_LEAD;
          end else if (hdr_scan.length_seen) begin
            if (len_scan == '0) hit_done = 1'b1;
            else phase_step = PH_BODY_LEN;
          end else if (hdr_scan.status_value == STATUS_NO_CONTENT) begin
            hit_done = 1'b1;
          end else begin
            phase_step = PH_BODY_RAW;
          end
        end
      end
      PH_BODY_LEN: begin
        is_content  = 1'b1;
        length_next = len_dec;
        if (len_dec == '0) hit_done = 1'b1;
      end
      PH_BODY_RAW: is_content = 1'b1;
      PH_CH_LEAD: begin
        if (!hx[4]) begin
          chunk_next = LENGTH_WIDTH'(hx[3:0]);
          phase_step = PH_CH_DIGIT;
        end else if (b != CH_SPACE) begin
          hit_done = 1'b1;
          hit_err  = ERR_CHUNK;
        end
      end
      PH_CH_DIGIT: begin
        if (!hx[4]) chunk_next = chunk_acc;
        else phase_step = (b == CH_CR) ? PH_CH_LF : PH_CH_EXT;
      end
      PH_CH_EXT: if (b == CH_CR) phase_step = PH_CH_LF;
      PH_CH_LF: begin
        if (b == CH_LF) begin
          if (chunk_remaining == '0) hit_done = 1'b1;
          else phase_step = PH_CH_DATA;
        end else if (b != CH_CR) begin
          phase_step = PH_CH_EXT;
        end
      end
      PH_CH_DATA: begin
        is_content = 1'b1;
        chunk_next = chunk_dec;
        if (chunk_dec == '0) phase_step = PH_CH_TCR;
      end
      PH_CH_TCR: begin
        if (b == CH_CR) phase_step = PH_CH_TLF;
        else begin
          hit_done = 1'b1;
          hit_err  = ERR_CHUNK;
        end
      end
      PH_CH_TLF: begin
        if (b == CH_LF) phase_step = PH_CH_LEAD;
        else begin
          hit_done = 1'b1;
          hit_err  = ERR_CHUNK;
        end
      end
      default: phase_step = PH_DONE;
    endcase
  end

  // result fields
  always_comb begin
    fin_done = hit_done || (bytes.end_of_data && phase_step != PH_DONE);
    fin_err  = hit_err;
    if (!hit_done) begin
      unique case (phase_step)
        PH_HEADER: begin
          if (!hdr_next.status_seen) fin_err = ERR_NO_STATUS;
          else if (hdr_next.chunked) fin_err = ERR_NO_HDR_END;
          else fin_err = ERR_OK;
        end
        PH_BODY_LEN: fin_err = ERR_LENGTH;
        PH_BODY_RAW: fin_err = ERR_OK;
        default:     fin_err = ERR_CHUNK;
      endcase
    end
    cls = is_content ? CLS_CONTENT : (is_hdr ? CLS_HEADER : CLS_FRAMING);
    count_next = (is_content && content_counter != '1) ? content_counter + 32'd1
                                                       : content_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      hdr             <= '0;
      length_value    <= '0;
      chunk_remaining <= '0;
      content_counter <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (bytes.ready) out_valid <= bytes.valid;
      if (accept) begin
        if (bytes.end_of_data) begin
          phase           <= PH_HEADER;
          hdr             <= '0;
          length_value    <= '0;
          chunk_remaining <= '0;
          content_counter <= '0;
        end else begin
          phase           <= fin_done ? PH_DONE : phase_step;
          hdr             <= hdr_next;
          length_value    <= length_next;
          chunk_remaining <= chunk_next;
          content_counter <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.data_byte   <= (cls != CLS_FRAMING) ? b : 8'd0;
      result.byte_class  <= cls;
      result.done_res    <= fin_done;
      result.status_code <= fin_done ? hdr_next.status_value : 16'd0;
      result.error_code  <= fin_done ? fin_err : ERR_OK;
      result.body_count  <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_quiet_unless_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.done_res |-> result.error_code == ERR_OK
                                      && result.status_code == 16'd0)
    else $error("status or error shown without done");
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result.byte_class != 2'd3)
    else $error("illegal byte class");
  a_framing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.byte_class == CLS_FRAMING |-> result.data_byte == 8'd0)
    else $error("framing byte not zeroed");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid && phase == PH_HEADER)
    else $error("not idle after reset");
`endif

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for http_response_dechunker_top: random HTTP responses
// are fed in and each tagged result item is checked against a local predictor.
// Depends on hrd_pkg, hrd_if and the dechunker RTL.
module tb_top;
  import hrd_pkg::*;

  typedef struct {
    logic [7:0]  data;
    logic [1:0]  cls;
    logic        done;
    logic [15:0] status;
    logic [2:0]  err;
    logic [31:0] count;
  } tag_t;

  class dechunk_scoreboard;
    localparam longint unsigned LEN_MAX = 64'hFFFF_FFFF;
    string status_pat = "HTTP/1.1 ";
    string length_pat = "\r\nContent-Length:";
    string chunked_pat = "\r\nTransfer-Encoding: chunked";
    phase_t phase;
    int unsigned st_pos, ln_pos, ck_pos, end_pos;
    int unsigned status_val;
    bit status_seen, length_seen, chunked;
    longint unsigned length_left, chunk_left;
    logic [31:0] content_cnt;
    tag_t expected_tags[$];
    int mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      phase = PH_HEADER;
      st_pos = 0; ln_pos = 0; ck_pos = 0; end_pos = 0;
      status_val = 0; status_seen = 0; length_seen = 0; chunked = 0;
      length_left = 0; chunk_left = 0; content_cnt = 0;
    endfunction

    function int unsigned step_match(string pat, int unsigned pos, logic [7:0] b);
      if (b == pat[pos]) return pos + 1;
      return (b == pat[0]) ? 1 : 0;
    endfunction

    function int unsigned hex_of(logic [7:0] b);
      if (b >= "0" && b <= "9") return b - "0";
      if (b >= "a" && b <= "f") return b - "a" + 10;
      if (b >= "A" && b <= "F") return b - "A" + 10;
      return 16;
    endfunction

    function longint unsigned sat_mac(longint unsigned v, int unsigned base,
                                      int unsigned d);
      if (v > (LEN_MAX - d) / base) return LEN_MAX;
      return v * base + d;
    endfunction

    // returns 1 when the blank line closes the header
    function bit scan_header(logic [7:0] b);
      bit dig;
      dig = (b >= "0" && b <= "9");
      if (st_pos < ST_SPACE) begin
        if (st_pos == 7 && b == CH_ZERO) st_pos = 8;
        else st_pos = step_match(status_pat, st_pos, b);
      end else if (st_pos == ST_SPACE) begin
        if (dig) begin
          status_val = b - "0"; status_seen = 1; st_pos = ST_DIGITS;
        end else if (b != CH_SPACE) st_pos = ST_FIN;
      end else if (st_pos == ST_DIGITS) begin
        if (dig) begin
          status_val = status_val * 10 + (b - "0");
          if (status_val > 65535) status_val = 65535;
        end else st_pos = ST_FIN;
      end
      if (ln_pos < LN_SPACE) ln_pos = step_match(length_pat, ln_pos, b);
      else if (ln_pos == LN_SPACE) begin
        if (dig) begin
          length_left = b - "0"; length_seen = 1; ln_pos = LN_DIGITS;
        end else if (b != CH_SPACE) ln_pos = LN_FIN;
      end else if (ln_pos == LN_DIGITS) begin
        if (dig) length_left = sat_mac(length_left, 10, b - "0");
        else ln_pos = LN_FIN;
      end
      if (ck_pos < CK_FOUND) begin
        ck_pos = step_match(chunked_pat, ck_pos, b);
        if (ck_pos == CK_FOUND) chunked = 1;
      end
      case (end_pos)
        0: end_pos = (b == CH_CR) ? 1 : 0;
        1: end_pos = (b == CH_LF) ? 2 : ((b == CH_CR) ? 1 : 0);
        2: end_pos = (b == CH_CR) ? 3 : 0;
        default: begin
          if (b == CH_LF) begin
            end_pos = 0;
            return 1;
          end
          end_pos = (b == CH_CR) ? 1 : 0;
        end
      endcase
      return 0;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      tag_t t;
      bit done, content;
      int unsigned d;
      logic [2:0] err;
      done = 0; content = 0; err = ERR_OK;
      t.cls = CLS_FRAMING;
      case (phase)
        PH_HEADER: begin
          t.cls = CLS_HEADER;
          if (scan_header(b)) begin
            if (!status_seen) begin
              done = 1; err = ERR_NO_STATUS;
            end else if (chunked) phase = PH_CH_LEAD;
            else if (length_seen) begin
              if (length_left == 0) done = 1;
              else phase = PH_BODY_LEN;
            end else if (status_val == STATUS_NO_CONTENT) done = 1;
            else phase = PH_BODY_RAW;
          end
        end
        PH_BODY_LEN: begin
          content = 1;
          if (length_left > 0) length_left--;
          if (length_left == 0) done = 1;
        end
        PH_BODY_RAW: content = 1;
        PH_CH_LEAD: begin
          d = hex_of(b);
          if (d < 16) begin
            chunk_left = d; phase = PH_CH_DIGIT;
          end else if (b != CH_SPACE) begin
            done = 1; err = ERR_CHUNK;
          end
        end
        PH_CH_DIGIT: begin
          d = hex_of(b);
          if (d < 16) chunk_left = sat_mac(chunk_left, 16, d);
          else phase = (b == CH_CR) ? PH_CH_LF : PH_CH_EXT;
        end
        PH_CH_EXT: if (b == CH_CR) phase = PH_CH_LF;
        PH_CH_LF: begin
          if (b == CH_LF) begin
            if (chunk_left == 0) done = 1;
            else phase = PH_CH_DATA;
          end else if (b != CH_CR) phase = PH_CH_EXT;
        end
        PH_CH_DATA: begin
          content = 1;
          if (chunk_left > 0) chunk_left--;
          if (chunk_left == 0) phase = PH_CH_TCR;
        end
        PH_CH_TCR: begin
          if (b == CH_CR) phase = PH_CH_TLF;
          else begin
            done = 1; err = ERR_CHUNK;
          end
        end
        PH_CH_TLF: begin
          if (b == CH_LF) phase = PH_CH_LEAD;
          else begin
            done = 1; err = ERR_CHUNK;
          end
        end
        default: phase = PH_DONE;
      endcase
      if (content) begin
        t.cls = CLS_CONTENT;
        if (content_cnt != 32'hFFFF_FFFF) content_cnt++;
      end
      if (done) phase = PH_DONE;
      else if (last && phase != PH_DONE) begin
        done = 1;
        if (phase == PH_HEADER)
          err = !status_seen ? ERR_NO_STATUS : (chunked ? ERR_NO_HDR_END : ERR_OK);
        else if (phase == PH_BODY_LEN) err = ERR_LENGTH;
        else if (phase == PH_BODY_RAW) err = ERR_OK;
        else err = ERR_CHUNK;
      end
      t.data = (t.cls != CLS_FRAMING) ? b : 8'h00;
      t.done = done;
      t.status = done ? status_val[15:0] : 16'h0;
      t.err = done ? err : ERR_OK;
      t.count = content_cnt;
      expected_tags.push_back(t);
      if (last) clear();
    endfunction

    function void check_tag(tag_t got);
      tag_t e;
      if (expected_tags.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item data=%h", got.data);
        return;
      end
      e = expected_tags.pop_front();
      if (got.data !== e.data || got.cls !== e.cls || got.done !== e.done ||
          got.status !== e.status || got.err !== e.err || got.count !== e.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp data=%h cls=%0d done=%0d st=%0d err=%0d cnt=%0d",
                    " / got data=%h cls=%0d done=%0d st=%0d err=%0d cnt=%0d"},
                   e.data, e.cls, e.done, e.status, e.err, e.count,
                   got.data, got.cls, got.done, got.status, got.err, got.count);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  hrd_in_if bytes_ch();
  hrd_out_if result_ch();

  http_response_dechunker_top i_dut (
    .clk(clk), .rst(rst), .bytes(bytes_ch.sink), .result(result_ch.source)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  dechunk_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int sent = 0;
  logic [7:0] msg[$];

  always @(posedge clk) begin
    if (rst) result_ch.ready <= 0;
    else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 300;
      result_ch.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 0;
    end else result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    tag_t got;
    if (!rst) begin
      if (bytes_ch.valid && bytes_ch.ready)
        sb.note_byte(bytes_ch.rx_byte, bytes_ch.end_of_data);
      if (result_ch.valid && result_ch.ready) begin
        got.data = result_ch.data_byte;
        got.cls = result_ch.byte_class;
        got.done = result_ch.done_res;
        got.status = result_ch.status_code;
        got.err = result_ch.error_code;
        got.count = result_ch.body_count;
        sb.check_tag(got);
      end
      if ((bytes_ch.valid && bytes_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > 5000) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function void add_str(string s);
    foreach (s[i]) msg.push_back(s[i]);
  endfunction

  function void add_spaces();
    repeat ($urandom_range(2)) msg.push_back(CH_SPACE);
  endfunction

  function void build_response();
    int mode, n, sz;
    string hx;
    msg.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(255)));
      return;
    end
    add_str($urandom_range(1) ? "HTTP/1.1" : "HTTP/1.0");
    add_str(" ");
    add_spaces();
    case ($urandom_range(9))
      0: add_str("204");
      1: add_str("9999999");
      2: ;
      default: add_str($sformatf("%0d", $urandom_range(100, 599)));
    endcase
    add_str("\r\nServer: x\r\n");
    mode = $urandom_range(3);
    if (mode == 0 || $urandom_range(7) == 0) begin
      add_str("Content-Length:");
      add_spaces();
      if ($urandom_range(15) == 0) add_str("99999999999");
      else add_str($sformatf("%0d", $urandom_range(0, 12)));
      add_str("\r\n");
    end
    if (mode == 1 || mode == 2) add_str("Transfer-Encoding: chunked\r\n");
    add_str("\r\n");
    if (mode == 1 || mode == 2) begin
      repeat ($urandom_range(3)) begin
        sz = $urandom_range(1, 12);
        add_spaces();
        hx = $sformatf("%0h", sz);
        if ($urandom_range(1)) hx = hx.toupper();
        if ($urandom_range(9) == 0) hx = {"000", hx};
        add_str(hx);
        if ($urandom_range(3) == 0) add_str(";ext=1");
        add_str("\r\n");
        repeat (sz) msg.push_back(8'($urandom_range(255)));
        add_str("\r\n");
      end
      if ($urandom_range(20) == 0) add_str("FFFFFFFFFFFF\r\n");
      add_str("0\r\n\r\n");
    end else repeat ($urandom_range(0, 14)) msg.push_back(8'($urandom_range(255)));
    n = msg.size();
    if ($urandom_range(7) == 0) msg[$urandom_range(n - 1)] = 8'($urandom_range(255));
    if ($urandom_range(7) == 0) msg = msg[0:$urandom_range(n - 1)];
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      bytes_ch.valid <= 0;
      @(posedge clk);
    end
    bytes_ch.valid <= 1;
    bytes_ch.rx_byte <= b;
    bytes_ch.end_of_data <= last;
    do @(posedge clk); while (!bytes_ch.ready);
    sent++;
  endtask

  task automatic send_msg();
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
    bytes_ch.valid <= 0;
  endtask

  task automatic drain();
    while (sb.expected_tags.size() != 0) @(posedge clk);
  endtask

  initial begin
    int target;
    bytes_ch.valid = 0;
    bytes_ch.rx_byte = 0;
    bytes_ch.end_of_data = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    msg.delete();
    add_str("HTTP/1.0 204\r\n\r\n");
    send_msg();
    msg.delete();
    msg.push_back(8'hFF);
    msg.push_back(8'h00);
    send_msg();
    @(posedge clk);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 77; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 77; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      if (ph == 0) hold_req++;
      target = sent + 460;
      while (sent < target) begin
        build_response();
        send_msg();
        if ($urandom_range(9) == 0) begin
          @(posedge clk);
          drain();
        end
      end
      @(posedge clk);
      drain();
    end
    drain();
    repeat (5) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_tags.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

>>> filelist.f
sv/hrd_pkg.sv
sv/hrd_if.sv
sv/hrd_hdr_scan.sv
sv/http_response_dechunker_top.sv
verif/tb_top.sv
